@@ hdl/dvrs_pkg.sv @@
// Shared constants, types and conversion functions for the decimal record serializer.
`default_nettype none

package dvrs_pkg;

	// Number format: at most this many decimal digits per field
	localparam int MAX_DIGITS  = 6;
	// Longest record kept; bytes past this are dropped
	localparam int MAX_RESULTS = 24;
	// Numeric fields per report: board id, sensor id, reading
	localparam int NUM_FIELDS  = 3;

	// 10^n, evaluated at elaboration
	function automatic int unsigned pow10(input int n);
		int unsigned r;
		r = 1;
		for (int k = 0; k < n; k++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam int unsigned DIGIT_LIMIT = pow10(MAX_DIGITS);
	// Binary width that holds any printable value
	localparam int BIN_W     = $clog2(DIGIT_LIMIT);
	// Double-dabble is split over this many pipeline stages
	localparam int DD_STAGES = 4;
	localparam int STEP_BITS = (BIN_W + DD_STAGES - 1) / DD_STAGES;
	localparam int PAD_W     = DD_STAGES * STEP_BITS;
	localparam int BCD_W     = 4 * MAX_DIGITS;
	localparam int DIG_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
	localparam int CNT_W     = $clog2(MAX_RESULTS);

	// ASCII codes
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// One sensor report
	typedef struct packed {
		logic signed [15:0] board_id;
		logic signed [15:0] sensor_id;
		logic signed [31:0] reading;
	} report_t;

	// One record byte
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_byte;
	} text_t;

	typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

	// Double-dabble working pair: remaining binary bits and BCD accumulator
	typedef struct packed {
		logic [PAD_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} dd_t;

	// Conversion pipeline stage contents
	typedef struct packed {
		logic [NUM_FIELDS-1:0] inr;
		dd_t  [NUM_FIELDS-1:0] dd;
	} conv_t;

	// Finished record fields, ready for the byte sequencer
	typedef struct packed {
		bcd_t [NUM_FIELDS-1:0]             bcd;
		logic [NUM_FIELDS-1:0][NDIG_W-1:0] ndig;
	} rec_t;

	// STEP_BITS shift-and-add-3 steps of double-dabble
	function automatic dd_t dd_chunk(input dd_t x);
		dd_t r;
		r = x;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (r.bcd[4*d +: 4] >= 4'd5) begin
					r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
				end
			end
			r.bcd = {r.bcd[BCD_W-2:0], r.bin[PAD_W-1]};
			r.bin = {r.bin[PAD_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Printed digit count: zero when out of range, at least one otherwise
	function automatic logic [NDIG_W-1:0] ndig_of(input bcd_t b, input logic inr);
		logic [NDIG_W-1:0] n;
		n = inr ? NDIG_W'(1) : '0;
		for (int d = 1; d < MAX_DIGITS; d++) begin
			if (inr && (b[d] != 4'd0)) begin
				n = NDIG_W'(d + 1);
			end
		end
		return n;
	endfunction

	// Every nibble is a decimal digit
	function automatic logic bcd_ok(input bcd_t b);
		logic ok;
		ok = 1'b1;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (b[d] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

@@ hdl/decimal_value_record_serializer.sv @@
// Sensor report to ASCII decimal record serializer: conversion pipeline and byte sequencer.
//
// Usage:
//   report channel (report_valid/report_ready/report) takes one sensor report:
//   board id, sensor id, reading. text channel (text_valid/text_ready/text)
//   sends the record one byte per transfer: 'V' ',' board ',' sensor ','
//   reading CR LF, last_byte set on the LF. A field outside 0..999999 sends
//   no digits but keeps its separators; numbers have no leading zeros.
// Path: the first byte reaches text through the input register, four
//   double-dabble stages, the digit-count stage and the sequencer's record
//   register, then the sequencer loads the output register.
// Throughput: one byte per cycle on text while text_ready is high; a record
//   is 6 to 22 bytes, 6 plus its printed digit count (16-bit ids print at
//   most five digits). The byte sequencer sets the rate: it takes the next
//   record in the cycle it sends the last byte of the current one, while up
//   to six more reports wait in the conversion stages.
// Reset: arst_n clears all valid bits and the sequencer; no item is in
//   flight afterwards.
// Stall: when text_ready is low the output register holds its byte, the
//   sequencer waits, and the conversion stages fill up and then drop
//   report_ready; nothing is lost or repeated.
`default_nettype none

module decimal_value_record_serializer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              report_valid,
	output logic             report_ready,
	input  wire dvrs_pkg::report_t report,
	output logic             text_valid,
	input  wire              text_ready,
	output dvrs_pkg::text_t  text
);

	// Sequencer phase codes
	localparam logic [3:0] PH_V  = 4'd0;
	localparam logic [3:0] PH_C0 = 4'd1;
	localparam logic [3:0] PH_N0 = 4'd2;
	localparam logic [3:0] PH_C1 = 4'd3;
	localparam logic [3:0] PH_N1 = 4'd4;
	localparam logic [3:0] PH_C2 = 4'd5;
	localparam logic [3:0] PH_N2 = 4'd6;
	localparam logic [3:0] PH_CR = 4'd7;
	localparam logic [3:0] PH_LF = 4'd8;

	localparam logic [31:0] LIMIT32 = 32'(dvrs_pkg::DIGIT_LIMIT);

	// Pipeline registers
	dvrs_pkg::conv_t pl_s1, pl_s2, pl_s3, pl_s4, pl_s5;
	dvrs_pkg::rec_t  pl_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic load_s1, load_s2, load_s3, load_s4, load_s5, load_s6;

	// Next-stage values
	dvrs_pkg::conv_t in_conv, nx_s2, nx_s3, nx_s4, nx_s5;
	dvrs_pkg::rec_t  nx_s6;

	// Sequencer and output register
	dvrs_pkg::rec_t          rec_q;
	logic                    ser_busy_q;
	logic [3:0]              phase_q;
	logic [dvrs_pkg::DIG_W-1:0] dig_q;
	logic [dvrs_pkg::CNT_W-1:0] cnt_q;
	logic                    out_valid_q;
	dvrs_pkg::text_t         out_q;

	logic                    out_load;
	logic                    is_last;
	logic                    ser_take;
	logic [7:0]              ch_d;
	logic [3:0]              phase_d;
	logic [dvrs_pkg::DIG_W-1:0] dig_d;

	// Stall chain: a stage loads when empty or when its content moves on
	assign out_load  = ser_busy_q && (!out_valid_q || text_ready);
	assign is_last   = (phase_q == PH_LF) || (cnt_q == dvrs_pkg::CNT_W'(dvrs_pkg::MAX_RESULTS - 1));
	assign ser_take  = !ser_busy_q || (out_load && is_last);
	assign load_s6   = !v_s6 || ser_take;
	assign load_s5   = !v_s5 || load_s6;
	assign load_s4   = !v_s4 || load_s5;
	assign load_s3   = !v_s3 || load_s4;
	assign load_s2   = !v_s2 || load_s3;
	assign load_s1   = !v_s1 || load_s2;
	assign report_ready = load_s1;

	// Range check and binary setup for the input register
	always_comb begin
		in_conv = '0;
		in_conv.inr[0] = !report.board_id[15]
			&& ({16'b0, report.board_id} < LIMIT32);
		in_conv.inr[1] = !report.sensor_id[15]
			&& ({16'b0, report.sensor_id} < LIMIT32);
		in_conv.inr[2] = !report.reading[31] && (report.reading < LIMIT32);
		in_conv.dd[0].bin = in_conv.inr[0] ?
			dvrs_pkg::PAD_W'({16'b0, report.board_id}) : '0;
		in_conv.dd[1].bin = in_conv.inr[1] ?
			dvrs_pkg::PAD_W'({16'b0, report.sensor_id}) : '0;
		in_conv.dd[2].bin = in_conv.inr[2] ?
			dvrs_pkg::PAD_W'(report.reading) : '0;
	end

	// Double-dabble chunks, one per stage
	always_comb begin
		nx_s2 = pl_s1;
		nx_s3 = pl_s2;
		nx_s4 = pl_s3;
		nx_s5 = pl_s4;
		for (int f = 0; f < dvrs_pkg::NUM_FIELDS; f++) begin
			nx_s2.dd[f] = dvrs_pkg::dd_chunk(pl_s1.dd[f]);
			nx_s3.dd[f] = dvrs_pkg::dd_chunk(pl_s2.dd[f]);
			nx_s4.dd[f] = dvrs_pkg::dd_chunk(pl_s3.dd[f]);
			nx_s5.dd[f] = dvrs_pkg::dd_chunk(pl_s4.dd[f]);
		end
	end

	// Digit counts for the finished conversions
	always_comb begin
		for (int f = 0; f < dvrs_pkg::NUM_FIELDS; f++) begin
			nx_s6.bcd[f]  = dvrs_pkg::bcd_t'(pl_s5.dd[f].bcd);
			nx_s6.ndig[f] = dvrs_pkg::ndig_of(dvrs_pkg::bcd_t'(pl_s5.dd[f].bcd),
				pl_s5.inr[f]);
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (load_s1) v_s1 <= report_valid;
			if (load_s2) v_s2 <= v_s1;
			if (load_s3) v_s3 <= v_s2;
			if (load_s4) v_s4 <= v_s3;
			if (load_s5) v_s5 <= v_s4;
			if (load_s6) v_s6 <= v_s5;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (load_s1) pl_s1 <= in_conv;
		if (load_s2) pl_s2 <= nx_s2;
		if (load_s3) pl_s3 <= nx_s3;
		if (load_s4) pl_s4 <= nx_s4;
		if (load_s5) pl_s5 <= nx_s5;
		if (load_s6) pl_s6 <= nx_s6;
	end

	// Byte selection and next phase
	always_comb begin
		ch_d    = CH_V_F();
		phase_d = phase_q;
		dig_d   = dig_q;
		case (phase_q)
			PH_V: begin
				ch_d    = dvrs_pkg::CH_V;
				phase_d = PH_C0;
			end
			PH_C0: begin
				ch_d = dvrs_pkg::CH_COMMA;
				if (rec_q.ndig[0] != '0) begin
					phase_d = PH_N0;
					dig_d   = dvrs_pkg::DIG_W'(rec_q.ndig[0] - 1'b1);
				end else begin
					phase_d = PH_C1;
				end
			end
			PH_N0: begin
				ch_d = dvrs_pkg::CH_ZERO + {4'b0, rec_q.bcd[0][dig_q]};
				if (dig_q == '0) phase_d = PH_C1;
				else dig_d = dig_q - 1'b1;
			end
			PH_C1: begin
				ch_d = dvrs_pkg::CH_COMMA;
				if (rec_q.ndig[1] != '0) begin
					phase_d = PH_N1;
					dig_d   = dvrs_pkg::DIG_W'(rec_q.ndig[1] - 1'b1);
				end else begin
					phase_d = PH_C2;
				end
			end
			PH_N1: begin
				ch_d = dvrs_pkg::CH_ZERO + {4'b0, rec_q.bcd[1][dig_q]};
				if (dig_q == '0) phase_d = PH_C2;
				else dig_d = dig_q - 1'b1;
			end
			PH_C2: begin
				ch_d = dvrs_pkg::CH_COMMA;
				if (rec_q.ndig[2] != '0) begin
					phase_d = PH_N2;
					dig_d   = dvrs_pkg::DIG_W'(rec_q.ndig[2] - 1'b1);
				end else begin
					phase_d = PH_CR;
				end
			end
			PH_N2: begin
				ch_d = dvrs_pkg::CH_ZERO + {4'b0, rec_q.bcd[2][dig_q]};
				if (dig_q == '0) phase_d = PH_CR;
				else dig_d = dig_q - 1'b1;
			end
			PH_CR: begin
				ch_d    = dvrs_pkg::CH_CR;
				phase_d = PH_LF;
			end
			PH_LF: begin
				ch_d    = dvrs_pkg::CH_LF;
				phase_d = PH_LF;
			end
			default: begin
				ch_d    = dvrs_pkg::CH_LF;
				phase_d = PH_LF;
			end
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy_q <= 1'b0;
			phase_q    <= PH_V;
			dig_q      <= '0;
			cnt_q      <= '0;
		end else if (ser_take) begin
			ser_busy_q <= v_s6;
			phase_q    <= PH_V;
			dig_q      <= '0;
			cnt_q      <= '0;
		end else if (out_load) begin
			phase_q <= phase_d;
			dig_q   <= dig_d;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	// Record held while its bytes go out
	always_ff @(posedge clk) begin
		if (ser_take && v_s6) rec_q <= pl_s6;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (text_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.char_code <= ch_d;
			out_q.last_byte <= is_last;
		end
	end

	assign text_valid = out_valid_q;
	assign text       = out_q;

	// Default byte before the phase decode
	function automatic logic [7:0] CH_V_F();
		return dvrs_pkg::CH_V;
	endfunction

	// A record starts at byte zero
	a_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (phase_q == PH_V) |-> cnt_q == '0)
		else $error("record start byte sent at nonzero count");

	// Byte count stays within the record limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ser_busy_q |-> cnt_q <= dvrs_pkg::CNT_W'(dvrs_pkg::MAX_RESULTS - 1))
		else $error("record byte count overran");

	// Conversion has consumed every binary bit by the last dabble stage
	a_dd_done: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (pl_s5.dd[0].bin == '0) && (pl_s5.dd[1].bin == '0)
			&& (pl_s5.dd[2].bin == '0))
		else $error("binary bits left after conversion");

	// Converted digits are decimal
	a_bcd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> dvrs_pkg::bcd_ok(pl_s6.bcd[0]) && dvrs_pkg::bcd_ok(pl_s6.bcd[1])
			&& dvrs_pkg::bcd_ok(pl_s6.bcd[2]))
		else $error("non-decimal digit after conversion");

	// A stalled stage keeps its item
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !load_s6 |=> v_s5 && $stable(pl_s5))
		else $error("stalled conversion stage lost its item");

endmodule

`default_nettype wire
